// ----- design/fir_17tap_lowpass_dac_macros.svh -----
// Assertion macros for the FIR low-pass DAC filter.
// Included by design/fir_17tap_lowpass_dac.sv; depends on nothing else.
`ifndef FIR_17TAP_LOWPASS_DAC_MACROS_SVH
`define FIR_17TAP_LOWPASS_DAC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FIR17_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FIR17_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/fir17_pkg.sv -----
// Shared widths, types and tap coefficients of the FIR low-pass DAC filter.
// Used by fir17_tap_cell.sv and fir_17tap_lowpass_dac.sv.
package fir17_pkg;

   localparam int TAPS        = 17;
   localparam int SAMPLE_BITS = 10;
   localparam int COEF_BITS   = 16;
   localparam int ACC_BITS    = 32;
   localparam int CODE_BITS   = 8;
   localparam int CODE_LSB    = 17;
   localparam int COEF_COUNT  = 17;

   typedef logic        [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic        [CODE_BITS-1:0]   code_type;

   localparam coef_type COEF_TABLE [COEF_COUNT] = '{
      -16'sd248,  16'sd665,   16'sd940,   -16'sd190,  -16'sd2027, -16'sd1580,
      16'sd3123,  16'sd9688,  16'sd12808, 16'sd9688,  16'sd3123,  -16'sd1580,
      -16'sd2027, -16'sd190,  16'sd940,   16'sd665,   -16'sd248
   };

   // Taps past the end of the table weigh zero.
   function automatic coef_type coef_of(input int idx);
      coef_type c;
      c = '0;
      if (idx >= 0 && idx < COEF_COUNT) begin
         c = COEF_TABLE[idx];
      end
      return c;
   endfunction

endpackage

// ----- design/fir17_tap_cell.sv -----
// One cell of the transposed-form tap chain: multiply the new sample by its
// coefficient, add the partial sum from the older neighbor, hold the result.
// Depends on fir17_pkg.
module fir17_tap_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  fir17_pkg::sample_type sample,
   input  fir17_pkg::coef_type  coef,
   input  fir17_pkg::acc_type   sum_from_older,
   output fir17_pkg::acc_type   sum_out
);

   fir17_pkg::acc_type sum_ff;
   fir17_pkg::acc_type sum_in;
   fir17_pkg::acc_type sample_ext;
   fir17_pkg::acc_type coef_ext;
   fir17_pkg::acc_type product;

   always_comb begin
      sample_ext = fir17_pkg::acc_type'({{(fir17_pkg::ACC_BITS - fir17_pkg::SAMPLE_BITS){1'b0}},
                                         sample});
      coef_ext   = fir17_pkg::acc_type'(coef);
      // Product wraps modulo 2^32 like the accumulator.
      product    = sample_ext * coef_ext;
      sum_in     = sum_ff;
      if (advance) begin
         sum_in = product + sum_from_older;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ----- design/fir_17tap_lowpass_dac.sv -----
// 17-tap symmetric low-pass FIR driving an 8-bit DAC code.
// The result of an item is on rsp_ in the cycle after it is accepted.
// Throughput: one item per cycle while req_stall is low; the systolic tap chain advances once per item.
// The newest cell's register is the output register; req_stall rises only while
// a result waits under rsp_stall. Synchronous reset clears all partial sums
// (history counts as zero) and drops rsp_valid.
`include "fir_17tap_lowpass_dac_macros.svh"

module fir_17tap_lowpass_dac (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fir17_pkg::sample_type req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fir17_pkg::code_type   rsp_dac_code,
   output fir17_pkg::acc_type    rsp_full_sum
);

   fir17_pkg::acc_type chain_sum [fir17_pkg::TAPS+1];
   logic               advance;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = req_valid && !req_stall;

   // Oldest cell sees an empty partial sum.
   assign chain_sum[fir17_pkg::TAPS] = '0;

   for (genvar k = 0; k < fir17_pkg::TAPS; k++) begin : g_tap
      fir17_tap_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .sample         (req_sample),
         .coef           (fir17_pkg::coef_of(k)),
         .sum_from_older (chain_sum[k+1]),
         .sum_out        (chain_sum[k])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_full_sum = chain_sum[0];
   assign rsp_dac_code = rsp_full_sum[fir17_pkg::CODE_LSB +: fir17_pkg::CODE_BITS]
                         - fir17_pkg::code_type'(1);

   `FIR17_ASSERT_NEXT(a_accept_gives_result, advance, rsp_valid, "accepted item gave no result")
   `FIR17_ASSERT_NEXT(a_taken_no_new_clears, rsp_valid && !rsp_stall && !advance, !rsp_valid, "result repeated")
   `FIR17_ASSERT_NEXT(a_idle_chain_holds, !advance, $stable(chain_sum[1]), "tap chain moved without an item")
   `FIR17_ASSERT_NOW(a_reset_drops_valid, $past(reset), !rsp_valid, "result valid right after reset")

endmodule
